### design/cbpf_pkg.sv
// Package for the closable byte FIFO: sizes, operation and status codes, helpers.
package cbpf_pkg;

  // Number of byte entries in the store
  localparam int unsigned CAPACITY = 65536;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  // Fill level runs 0..CAPACITY inclusive
  localparam int unsigned FILL_W   = $clog2(CAPACITY + 1);

  // Fixed widths of the transfer fields
  localparam int unsigned OP_W     = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 17;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE       = 3'd0,
    OP_READ        = 3'd1,
    OP_SHUT_WRITE  = 3'd2,
    OP_SHUT_READ   = 3'd3,
    OP_QUERY_READ  = 3'd4,
    OP_QUERY_WRITE = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BLOCK  = 2'd1,
    ST_CLOSED = 2'd2
  } status_t;

  // Step a store position, wrapping at the capacity
  function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] pos);
    logic [ADDR_W-1:0] res;
    if (pos == ADDR_W'(CAPACITY - 1)) begin
      res = '0;
    end else begin
      res = pos + ADDR_W'(1);
    end
    return res;
  endfunction

  // Fit a fill-sized value into the count field, keeping the low bits
  function automatic logic [COUNT_W-1:0] to_count(input logic [FILL_W-1:0] val);
    logic [FILL_W+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, val};
    return ext[COUNT_W-1:0];
  endfunction

endpackage

### design/cbpf_if.sv
// Valid/ready channel interfaces for the FIFO's operation and result transfers.
interface cbpf_in_if;
  logic                          valid;
  logic                          ready;
  logic [cbpf_pkg::OP_W-1:0]     opcode;
  logic [cbpf_pkg::BYTE_W-1:0]   write_byte;
  logic                          block_end;

  modport source (output valid, output opcode, output write_byte, output block_end,
                  input ready);
  modport sink   (input valid, input opcode, input write_byte, input block_end,
                  output ready);
endinterface

interface cbpf_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status_code;
  logic [cbpf_pkg::BYTE_W-1:0]   read_byte;
  logic [cbpf_pkg::COUNT_W-1:0]  count;
  logic                          block_end_out;

  modport source (output valid, output status_code, output read_byte, output count,
                  output block_end_out, input ready);
  modport sink   (input valid, input status_code, input read_byte, input count,
                  input block_end_out, output ready);
endinterface

### design/closable_byte_pipe_fifo.sv
// Top level of the closable byte FIFO: control state, byte store and result register.
//
// Byte FIFO with a closable write side. Every operation transfer (write, read, shut
// write, shut read, read query, write query) yields exactly one result transfer via
// the result register. One operation is taken per clock cycle unless results stall: all
// control work for an operation is done between the input handshake and the result
// register, and the byte store has one write port and one registered read port, so a
// read's byte is fetched in the same cycle that the operation is taken. The input is
// ready whenever the result register is empty or its result is being taken, so a
// stalled result sink holds the input off after one outstanding result. Stored bytes
// need no clearing after reset: a read only ever reaches entries already written.
module closable_byte_pipe_fifo (
  input  logic             clk,
  input  logic             rst_n,
  cbpf_in_if.sink          in_ch,
  cbpf_out_if.source       out_ch
);

  // Control state
  logic [cbpf_pkg::ADDR_W-1:0]  head_r, head_nxt;
  logic [cbpf_pkg::ADDR_W-1:0]  tail_r, tail_nxt;
  logic [cbpf_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic                         wopen_r, wopen_nxt;

  // Result register
  logic                         out_valid_r;
  cbpf_pkg::status_t            out_status_r, status_nxt;
  logic [cbpf_pkg::COUNT_W-1:0] out_count_r, count_nxt;
  logic                         out_be_r;
  logic                         out_rd_ok_r;

  // Byte store
  logic [cbpf_pkg::BYTE_W-1:0]  mem [cbpf_pkg::CAPACITY];
  logic [cbpf_pkg::BYTE_W-1:0]  mem_q_r;

  logic in_xfer;
  logic empty;
  logic full;
  logic wr_en;
  logic rd_en;
  cbpf_pkg::op_t op;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign op          = cbpf_pkg::op_t'(in_ch.opcode);
  assign empty       = (fill_r == '0);
  assign full        = (fill_r == cbpf_pkg::FILL_W'(cbpf_pkg::CAPACITY));

  // Next state and result for the operation on the input
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    wopen_nxt  = wopen_r;
    status_nxt = cbpf_pkg::ST_OK;
    count_nxt  = '0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    case (op)
      cbpf_pkg::OP_WRITE: begin
        if (!wopen_r) begin
          status_nxt = cbpf_pkg::ST_CLOSED;
        end else if (full) begin
          status_nxt = cbpf_pkg::ST_BLOCK;
        end else begin
          wr_en    = 1'b1;
          tail_nxt = cbpf_pkg::next_pos(tail_r);
          fill_nxt = fill_r + cbpf_pkg::FILL_W'(1);
        end
      end
      cbpf_pkg::OP_READ: begin
        if (empty) begin
          status_nxt = wopen_r ? cbpf_pkg::ST_BLOCK : cbpf_pkg::ST_CLOSED;
        end else begin
          rd_en    = 1'b1;
          head_nxt = cbpf_pkg::next_pos(head_r);
          fill_nxt = fill_r - cbpf_pkg::FILL_W'(1);
          // draining the last byte rewinds both pointers
          if (fill_r == cbpf_pkg::FILL_W'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end
        end
      end
      cbpf_pkg::OP_SHUT_WRITE: begin
        wopen_nxt = 1'b0;
        if (empty) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
      end
      cbpf_pkg::OP_SHUT_READ: begin
        wopen_nxt = 1'b0;
        head_nxt  = '0;
        tail_nxt  = '0;
        fill_nxt  = '0;
      end
      cbpf_pkg::OP_QUERY_READ: begin
        if (empty) begin
          status_nxt = wopen_r ? cbpf_pkg::ST_BLOCK : cbpf_pkg::ST_CLOSED;
        end else begin
          count_nxt = cbpf_pkg::to_count(fill_r);
        end
      end
      cbpf_pkg::OP_QUERY_WRITE: begin
        if (!wopen_r) begin
          status_nxt = cbpf_pkg::ST_CLOSED;
        end else if (full) begin
          status_nxt = cbpf_pkg::ST_BLOCK;
        end else begin
          count_nxt = cbpf_pkg::to_count(cbpf_pkg::FILL_W'(cbpf_pkg::CAPACITY) - fill_r);
        end
      end
      default: begin
        // unused codes leave state alone and report ok
      end
    endcase
  end

  // Control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      wopen_r <= 1'b1;
    end else if (in_xfer) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      wopen_r <= wopen_nxt;
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_xfer && wr_en) begin
      mem[tail_r] <= in_ch.write_byte;
    end
    if (in_xfer && rd_en) begin
      mem_q_r <= mem[head_r];
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_status_r <= status_nxt;
      out_count_r  <= count_nxt;
      out_be_r     <= in_ch.block_end;
      out_rd_ok_r  <= rd_en;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status_code   = out_status_r;
  assign out_ch.read_byte     = out_rd_ok_r ? mem_q_r : '0;
  assign out_ch.count         = out_count_r;
  assign out_ch.block_end_out = out_be_r;

`ifndef SYNTHESIS
  // Fill level never passes the capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cbpf_pkg::FILL_W'(cbpf_pkg::CAPACITY))
    else $error("fill level beyond capacity");

  // An empty FIFO has its pointers together
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (head_r == tail_r))
    else $error("empty FIFO with pointers apart");

  // A taken write that succeeds raises the fill level by one
  a_write_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && op == cbpf_pkg::OP_WRITE && wopen_r && !full)
      |=> (fill_r == $past(fill_r) + cbpf_pkg::FILL_W'(1)))
    else $error("accepted write did not raise fill level");

  // Shutting either side leaves the write side closed
  a_shut_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (op == cbpf_pkg::OP_SHUT_WRITE || op == cbpf_pkg::OP_SHUT_READ))
      |=> !wopen_r)
    else $error("write side still open after shut");

  // A taken operation always leaves a result in the register
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("taken operation produced no result");
`endif

endmodule
